### design/dad_pkg.sv
// Shared constants, side-band type and elaboration-time helpers for the
// dihedral angle pipeline. No dependencies.
`default_nettype none

package dad_pkg;

  localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
  localparam int          MUL_LIMB    = 32;
  localparam int          MUL_LAT     = 5;
  localparam int          CHUNK       = 32;
  localparam int          C_SHIFT     = 60;
  localparam int          S_SHIFT     = 120;
  localparam int          SQW         = 122;
  localparam int          SQ_TW       = 128;
  localparam int          ROOT_W      = 62;
  localparam int          SQ_STEPS    = 62;
  localparam int          CORDIC_STEPS = 62;
  localparam int          CS_W        = 64;
  localparam int          ANGLE_SCALE = 180;

  typedef struct packed {
    logic neg;
    logic degen;
  } side_t;

  // Restoring long division, used only to build constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q61 radians from the alternating series.
  function automatic logic [63:0] atan_q61(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int n;
    sum = '0;
    n   = 0;
    if (i == 0) begin
      return PI_Q61 >> 2;
    end
    while (i * (2 * n + 1) <= 61) begin
      term = udiv64(64'd1 << (61 - i * (2 * n + 1)), 64'(2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
      n++;
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

### design/dad_in_if.sv
// Input channel carrying the four points of one quadruple.
// Depends on nothing.
`default_nettype none

interface dad_in_if #(parameter int CW = 24) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] p1_x, p1_y, p1_z;
  logic signed [CW-1:0] p2_x, p2_y, p2_z;
  logic signed [CW-1:0] p3_x, p3_y, p3_z;
  logic signed [CW-1:0] p4_x, p4_y, p4_z;

  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
  modport sink   (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

`default_nettype wire

### design/dad_out_if.sv
// Result channel carrying the signed torsion angle and the degenerate flag.
// Depends on nothing.
`default_nettype none

interface dad_out_if #(parameter int TW = 17) ();
  logic valid;
  logic ready;
  logic signed [TW-1:0] torsion_deg;
  logic degenerate;

  modport source (output valid, torsion_deg, degenerate, input ready);
  modport sink   (input valid, torsion_deg, degenerate, output ready);
endinterface

`default_nettype wire

### design/dad_mul.sv
// Pipelined signed multiplier built from 32 by 32 bit partial products.
// Depends on dad_pkg.
`default_nettype none

module dad_mul #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [WA-1:0]  a_i,
  input  logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import dad_pkg::*;

  localparam int NA   = (WA + MUL_LIMB - 1) / MUL_LIMB;
  localparam int NB   = (WB + MUL_LIMB - 1) / MUL_LIMB;
  localparam int AW   = NA * MUL_LIMB;
  localparam int BW   = NB * MUL_LIMB;
  localparam int PW   = AW + BW;
  localparam int ROWW = BW + MUL_LIMB;

  logic [WA-1:0]           abs_a;
  logic [WB-1:0]           abs_b;
  logic [AW-1:0]           ma_q;
  logic [BW-1:0]           mb_q;
  logic [3:0]              sg_q;
  logic [2*MUL_LIMB-1:0]   pp_q [NA][NB];
  logic [ROWW-1:0]         row_d [NA];
  logic [ROWW-1:0]         row_q [NA];
  logic [PW-1:0]           sum_d;
  logic [PW-1:0]           sum_q;
  logic signed [WA+WB-1:0] p_q;

  assign abs_a = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
  assign abs_b = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (ROWW'(pp_q[i][j]) << (MUL_LIMB * j));
      end
    end
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (PW'(row_q[i]) << (MUL_LIMB * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q <= AW'(abs_a);
      mb_q <= BW'(abs_b);
      sg_q <= {sg_q[2:0], a_i[WA-1] ^ b_i[WB-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= (2*MUL_LIMB)'(ma_q[i*MUL_LIMB +: MUL_LIMB])
                        * (2*MUL_LIMB)'(mb_q[j*MUL_LIMB +: MUL_LIMB]);
        end
      end
      row_q <= row_d;
      sum_q <= sum_d;
      p_q   <= sg_q[3] ? (WA+WB)'(-sum_q) : (WA+WB)'(sum_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### design/dad_sqrt_cell.sv
// One digit cell of the restoring square root row: settles one root bit.
// Depends on dad_pkg.
`default_nettype none

module dad_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [dad_pkg::SQW-1:0]    rem_i,
  input  logic [dad_pkg::ROOT_W-1:0] root_i,
  output logic [dad_pkg::SQW-1:0]    rem_o,
  output logic [dad_pkg::ROOT_W-1:0] root_o
);
  import dad_pkg::*;

  logic [SQ_TW-1:0]  trial;
  logic              fits;
  logic [SQW-1:0]    rem_q;
  logic [ROOT_W-1:0] root_q;

  // Setting this bit raises the square by 2*root*2^BIT + 4^BIT.
  assign trial = (SQ_TW'(root_i) << (BIT + 1)) + (SQ_TW'(1) << (2 * BIT));
  assign fits  = SQ_TW'(rem_i) >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= fits ? SQW'(SQ_TW'(rem_i) - trial) : rem_i;
      root_q <= fits ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### design/dad_cordic_cell.sv
// One CORDIC vectoring cell: rotates towards the x axis by atan(2^-IDX).
// Depends on dad_pkg.
`default_nettype none

module dad_cordic_cell #(
  parameter int          IDX  = 0,
  parameter logic [63:0] ATAN = 64'd0
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [dad_pkg::CS_W-1:0] x_i,
  input  logic signed [dad_pkg::CS_W-1:0] y_i,
  input  logic signed [dad_pkg::CS_W-1:0] z_i,
  output logic signed [dad_pkg::CS_W-1:0] x_o,
  output logic signed [dad_pkg::CS_W-1:0] y_o,
  output logic signed [dad_pkg::CS_W-1:0] z_o
);
  import dad_pkg::*;

  logic signed [CS_W-1:0] dx;
  logic signed [CS_W-1:0] dy;
  logic signed [CS_W-1:0] x_q, y_q, z_q;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!y_i[CS_W-1]) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + $signed(ATAN);
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - $signed(ATAN);
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

### design/dihedral_angle_four_points.sv
// Signed torsion angle of four points: exact integer normals, square root row,
// CORDIC row and a restoring scale divider. Depends on dad_pkg, dad_in_if,
// dad_out_if, dad_mul, dad_sqrt_cell and dad_cordic_cell.
//
//   channel   direction   beat contents
//   in_i      sink        p1_x .. p4_z, twelve signed coordinates
//   out_o     source      torsion_deg (1/2^ANGLE_FRAC_BITS degree), degenerate
//
// One beat is taken every cycle while the output is not stalled; each beat passes
// through the 62 square root cells, the 62 CORDIC cells and the divider.
// Reset clears only the valid bits of the stages. A stalled output freezes the
// whole row, so the input is held off only while the last stage is full and
// not taken.
`default_nettype none

module dihedral_angle_four_points #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dad_in_if.sink     in_i,
  dad_out_if.source  out_o
);
  import dad_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int LW   = CW + 1;
  localparam int PW2  = 2 * LW;
  localparam int NW   = PW2 + 1;
  localparam int LENW = 2 * NW;
  localparam int CCW  = 2 * NW + 1;
  localparam int DLW  = NW + LW + 1;
  localparam int RW   = 4 * NW;
  localparam int NCH  = (RW + CHUNK - 1) / CHUNK;
  localparam int RPW  = NCH * CHUNK;
  localparam int HW   = $clog2(RPW + 2);
  localparam int CSH  = CCW + C_SHIFT;
  localparam int SW2  = RW + S_SHIFT;
  localparam int TW   = ANGLE_FRAC_BITS + 9;
  localparam int QB   = ANGLE_FRAC_BITS + 10;
  localparam int NUMW = ANGLE_FRAC_BITS + 74;

  localparam int ST_L  = 0;
  localparam int ST_P  = ST_L + 1;
  localparam int ST_N  = ST_P + 1;
  localparam int ST_S  = ST_N + MUL_LAT + 1;
  localparam int ST_D  = ST_S + MUL_LAT + 1;
  localparam int ST_B  = ST_D + 1;
  localparam int ST_SH = ST_B + 1;
  localparam int ST_CI = ST_SH + SQ_STEPS + 1;
  localparam int ST_Q  = ST_CI + CORDIC_STEPS + 1;
  localparam int ST_O  = ST_Q + QB + 1;
  localparam int NST   = ST_O + 1;

  localparam logic signed [TW-1:0] MAXQ = TW'(ANGLE_SCALE << ANGLE_FRAC_BITS);
  localparam logic [NUMW-1:0]      DEN  = NUMW'(PI_Q61) << 1;

  logic           en;
  logic [NST-1:0] vld_q;

  logic signed [CW-1:0]  pin [4][3];
  logic signed [LW-1:0]  l1_q [3], l2_q [3], l3_q [3], l3d_q [3], l3n_q [3];
  logic signed [PW2-1:0] prd_q [12];
  logic signed [NW-1:0]  n1_q [3], n2_q [3];

  logic signed [2*NW-1:0]  sq1_p [3], sq2_p [3], cc_p [3];
  logic signed [NW+LW-1:0] dl_p [3];

  logic [LENW-1:0]       len1_q, len2_q;
  logic signed [CCW-1:0] c_q;
  logic signed [CCW-1:0] cd_q [MUL_LAT];
  logic signed [DLW-1:0] dnl;
  side_t                 side_q [ST_S:ST_O-1];

  logic signed [2*LENW+1:0] r_p;
  logic signed [2*CCW-1:0]  csq_p;
  logic [RPW-1:0]           r_pad;
  logic [5:0]               hp_d [NCH];
  logic [5:0]               hp_q [NCH];
  logic [RW-1:0]            s2_q, s2b_q;
  logic signed [CCW-1:0]    cc2_q, cb_q;
  logic [HW-1:0]            blen;
  logic [HW-1:0]            h_q;
  logic signed [CSH-1:0]    cwide;
  logic [SW2-1:0]           swide;

  logic [SQW-1:0]         sq_rem  [SQ_STEPS+1];
  logic [ROOT_W-1:0]      sq_root [SQ_STEPS+1];
  logic signed [CS_W-1:0] cs_q    [SQ_STEPS+1];

  logic signed [CS_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] cz [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] cs_fin;
  logic signed [CS_W-1:0] zc;

  logic [NUMW-1:0] drem [QB+1];
  logic [QB-1:0]   dq   [QB+1];

  logic signed [TW-1:0] tor_q;
  logic                 deg_q;

  // The whole row advances unless a finished beat is being held at the output.
  assign en          = !vld_q[ST_O] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[ST_O];
  assign out_o.torsion_deg = tor_q;
  assign out_o.degenerate  = deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  assign pin[0] = '{in_i.p1_x, in_i.p1_y, in_i.p1_z};
  assign pin[1] = '{in_i.p2_x, in_i.p2_y, in_i.p2_z};
  assign pin[2] = '{in_i.p3_x, in_i.p3_y, in_i.p3_z};
  assign pin[3] = '{in_i.p4_x, in_i.p4_y, in_i.p4_z};

  // Bond vectors, cross product terms and normals.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        l1_q[k]  <= LW'(pin[1][k]) - LW'(pin[0][k]);
        l2_q[k]  <= LW'(pin[2][k]) - LW'(pin[1][k]);
        l3_q[k]  <= LW'(pin[3][k]) - LW'(pin[2][k]);
        l3d_q[k] <= l3_q[k];
        l3n_q[k] <= l3d_q[k];
      end
      prd_q[0]  <= PW2'(l2_q[1]) * PW2'(l1_q[2]);
      prd_q[1]  <= PW2'(l2_q[2]) * PW2'(l1_q[1]);
      prd_q[2]  <= PW2'(l2_q[2]) * PW2'(l1_q[0]);
      prd_q[3]  <= PW2'(l2_q[0]) * PW2'(l1_q[2]);
      prd_q[4]  <= PW2'(l2_q[0]) * PW2'(l1_q[1]);
      prd_q[5]  <= PW2'(l2_q[1]) * PW2'(l1_q[0]);
      prd_q[6]  <= PW2'(l3_q[1]) * PW2'(l2_q[2]);
      prd_q[7]  <= PW2'(l3_q[2]) * PW2'(l2_q[1]);
      prd_q[8]  <= PW2'(l3_q[2]) * PW2'(l2_q[0]);
      prd_q[9]  <= PW2'(l3_q[0]) * PW2'(l2_q[2]);
      prd_q[10] <= PW2'(l3_q[0]) * PW2'(l2_q[1]);
      prd_q[11] <= PW2'(l3_q[1]) * PW2'(l2_q[0]);
      for (int k = 0; k < 3; k++) begin
        n1_q[k] <= NW'(prd_q[2*k]) - NW'(prd_q[2*k+1]);
        n2_q[k] <= NW'(prd_q[6+2*k]) - NW'(prd_q[6+2*k+1]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    dad_mul #(.WA(NW), .WB(NW)) u_sq1 (
      .clk_i(clk_i), .en_i(en), .a_i(n1_q[k]), .b_i(n1_q[k]), .p_o(sq1_p[k]));
    dad_mul #(.WA(NW), .WB(NW)) u_sq2 (
      .clk_i(clk_i), .en_i(en), .a_i(n2_q[k]), .b_i(n2_q[k]), .p_o(sq2_p[k]));
    dad_mul #(.WA(NW), .WB(NW)) u_cc (
      .clk_i(clk_i), .en_i(en), .a_i(n1_q[k]), .b_i(n2_q[k]), .p_o(cc_p[k]));
    dad_mul #(.WA(NW), .WB(LW)) u_dl (
      .clk_i(clk_i), .en_i(en), .a_i(n1_q[k]), .b_i(l3n_q[k]), .p_o(dl_p[k]));
  end

  assign dnl = DLW'(dl_p[0]) + DLW'(dl_p[1]) + DLW'(dl_p[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      len1_q <= LENW'(unsigned'(sq1_p[0])) + LENW'(unsigned'(sq1_p[1]))
                + LENW'(unsigned'(sq1_p[2]));
      len2_q <= LENW'(unsigned'(sq2_p[0])) + LENW'(unsigned'(sq2_p[1]))
                + LENW'(unsigned'(sq2_p[2]));
      c_q    <= CCW'(cc_p[0]) + CCW'(cc_p[1]) + CCW'(cc_p[2]);
      side_q[ST_S].neg   <= dnl[DLW-1];
      side_q[ST_S].degen <= (sq1_p[0] == '0) && (sq1_p[1] == '0) && (sq1_p[2] == '0)
                            || (sq2_p[0] == '0) && (sq2_p[1] == '0) && (sq2_p[2] == '0);
      cd_q[0] <= c_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        cd_q[k] <= cd_q[k-1];
      end
    end
  end

  for (genvar s = ST_S + 1; s < ST_O; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) side_q[s] <= side_q[s-1];
    end
  end

  dad_mul #(.WA(LENW+1), .WB(LENW+1)) u_rr (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, len1_q}), .b_i({1'b0, len2_q}), .p_o(r_p));
  dad_mul #(.WA(CCW), .WB(CCW)) u_csq (
    .clk_i(clk_i), .en_i(en), .a_i(c_q), .b_i(c_q), .p_o(csq_p));

  // Bit length of |n1|^2 |n2|^2, first per chunk and then across chunks.
  assign r_pad = RPW'(RW'(unsigned'(r_p)));

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      hp_d[ch] = '0;
      for (int b = 0; b < CHUNK; b++) begin
        if (r_pad[ch*CHUNK + b]) hp_d[ch] = 6'(b + 1);
      end
    end
    blen = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (hp_q[ch] != '0) blen = HW'(ch * CHUNK) + HW'(hp_q[ch]);
    end
  end

  assign cwide = CSH'(cb_q) <<< C_SHIFT;
  assign swide = SW2'(s2b_q) << S_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hp_q  <= hp_d;
      s2_q  <= RW'(unsigned'(r_p)) - RW'(unsigned'(csq_p));
      cc2_q <= cd_q[MUL_LAT-1];
      h_q   <= HW'((HW+1)'(blen) + (HW+1)'(1) >> 1);
      s2b_q <= s2_q;
      cb_q  <= cc2_q;
      // Scaling so that the larger of cosine and sine lands near 2^60, the sine square at most near 2^120.
      cs_q[0]    <= CS_W'(cwide >>> h_q);
      sq_rem[0]  <= SQW'(swide >> ((HW+1)'(h_q) << 1));
      sq_root[0] <= '0;
      for (int j = 1; j <= SQ_STEPS; j++) begin
        cs_q[j] <= cs_q[j-1];
      end
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    dad_sqrt_cell #(.BIT(SQ_STEPS - 1 - j)) u_cell (
      .clk_i(clk_i), .en_i(en),
      .rem_i(sq_rem[j]), .root_i(sq_root[j]),
      .rem_o(sq_rem[j+1]), .root_o(sq_root[j+1]));
  end

  assign cs_fin = cs_q[SQ_STEPS];

  // A negative cosine starts a quarter turn ahead so the rotation stays convergent.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (cs_fin[CS_W-1]) begin
        cx[0] <= CS_W'(sq_root[SQ_STEPS]);
        cy[0] <= -cs_fin;
        cz[0] <= $signed(PI_Q61 >> 1);
      end else begin
        cx[0] <= cs_fin;
        cy[0] <= CS_W'(sq_root[SQ_STEPS]);
        cz[0] <= '0;
      end
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    dad_cordic_cell #(.IDX(j), .ATAN(atan_q61(j))) u_cell (
      .clk_i(clk_i), .en_i(en),
      .x_i(cx[j]), .y_i(cy[j]), .z_i(cz[j]),
      .x_o(cx[j+1]), .y_o(cy[j+1]), .z_o(cz[j+1]));
  end

  always_comb begin
    if (cz[CORDIC_STEPS][CS_W-1]) zc = '0;
    else if (cz[CORDIC_STEPS] > $signed(PI_Q61)) zc = $signed(PI_Q61);
    else zc = cz[CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem[0] <= ((NUMW'(unsigned'(zc)) * NUMW'(ANGLE_SCALE)) << (ANGLE_FRAC_BITS + 1))
                 + NUMW'(PI_Q61);
      dq[0]   <= '0;
    end
  end

  // Rounded division by 2*pi, one quotient bit per stage, top bit first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    localparam logic [NUMW-1:0] DK = DEN << K;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (drem[j] >= DK) begin
          drem[j+1] <= drem[j] - DK;
          dq[j+1]   <= dq[j] | (QB'(1) << K);
        end else begin
          drem[j+1] <= drem[j];
          dq[j+1]   <= dq[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= side_q[ST_O-1].degen;
      if (side_q[ST_O-1].degen) tor_q <= '0;
      else if (side_q[ST_O-1].neg) tor_q <= TW'(dq[QB]);
      else tor_q <= TW'(-dq[QB]);
    end
  end

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |-> out_o.torsion_deg == '0)
    else $error("degenerate beat carries a non-zero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.torsion_deg <= MAXQ) && (out_o.torsion_deg >= -MAXQ))
    else $error("torsion angle outside half a turn");

  a_hold_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input held off without a stalled output");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(vld_q) && $stable(tor_q))
    else $error("row moved while the output was stalled");

endmodule

`default_nettype wire

### verif/dihedral_angle_four_points_tb.sv
// Self-checking bench for dihedral_angle_four_points: directed and random point
// quadruples, a bit-exact torsion predictor and an in-order result scoreboard.
// Depends on dad_pkg, dad_in_if, dad_out_if and the block itself.
`default_nettype none

module dihedral_angle_four_points_tb;
  import dad_pkg::*;

  localparam int CW        = 24;
  localparam int FRAC      = 8;
  localparam int TW        = FRAC + 9;
  localparam int N_RANDOM  = 1880;
  localparam int CALM_FROM = 1600;
  localparam int DRAIN     = 400;
  localparam int MAX_CYCLES = 300000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] quad_t [12];

  typedef struct {
    logic signed [TW-1:0] angle;
    logic                 degen;
  } torsion_t;

  class torsion_scoreboard;
    torsion_t          pending_q[$];
    logic signed [63:0] atan_tab[62];
    int                fails;

    function new();
      logic signed [63:0] sum;
      logic [63:0]        term;
      fails = 0;
      atan_tab[0] = $signed(PI_Q61 >> 2);
      for (int i = 1; i < 62; i++) begin
        sum = 0;
        for (int n = 0; i * (2 * n + 1) <= 61; n++) begin
          term = (64'd1 << (61 - i * (2 * n + 1))) / 64'(2 * n + 1);
          if (n % 2 == 1) sum = sum - $signed(term);
          else sum = sum + $signed(term);
        end
        atan_tab[i] = sum;
      end
    endfunction

    function torsion_t torsion_of(quad_t pt);
      wide_t    p[12];
      wide_t    l1[3], l2[3], l3[3], n1[3], n2[3];
      wide_t    len1, len2, c, r, s2, num, q, sgn_dot, tb;
      int       blen, e;
      logic signed [63:0] cs, x, y, z, dx, dy;
      logic [63:0] root, t;
      torsion_t res;
      for (int k = 0; k < 12; k++) p[k] = pt[k];
      for (int k = 0; k < 3; k++) begin
        l1[k] = p[3 + k] - p[k];
        l2[k] = p[6 + k] - p[3 + k];
        l3[k] = p[9 + k] - p[6 + k];
      end
      n1[0] = l2[1] * l1[2] - l2[2] * l1[1];
      n1[1] = l2[2] * l1[0] - l2[0] * l1[2];
      n1[2] = l2[0] * l1[1] - l2[1] * l1[0];
      n2[0] = l3[1] * l2[2] - l3[2] * l2[1];
      n2[1] = l3[2] * l2[0] - l3[0] * l2[2];
      n2[2] = l3[0] * l2[1] - l3[1] * l2[0];
      len1 = n1[0] * n1[0] + n1[1] * n1[1] + n1[2] * n1[2];
      len2 = n2[0] * n2[0] + n2[1] * n2[1] + n2[2] * n2[2];
      if (len1 == 0 || len2 == 0) begin
        res.angle = '0;
        res.degen = 1'b1;
        return res;
      end
      c  = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
      r  = len1 * len2;
      s2 = r - c * c;
      blen = 0;
      for (int b = 255; b >= 0; b--) begin
        if (r[b] && blen == 0) blen = b + 1;
      end
      e = (blen + 1) / 2 - 60;
      // Scale so that the larger of c and s sits near 2^60.
      if (e >= 0) begin
        c  = c >>> e;
        s2 = s2 >>> (2 * e);
      end else begin
        c  = c <<< (-e);
        s2 = s2 <<< (-2 * e);
      end
      cs = c[63:0];
      root = '0;
      for (int b = 61; b >= 0; b--) begin
        t  = root | (64'd1 << b);
        tb = $signed({192'd0, t});
        if (tb * tb <= s2) root = t;
      end
      if (cs < 0) begin
        x = $signed(root);
        y = -cs;
        z = $signed(PI_Q61 >> 1);
      end else begin
        x = cs;
        y = $signed(root);
        z = 0;
      end
      for (int i = 0; i < 62; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_tab[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_tab[i];
        end
      end
      if (z < 0) z = 0;
      if (z > $signed(PI_Q61)) z = $signed(PI_Q61);
      num = (wide_t'(z) * 180) <<< (FRAC + 1);
      num = num + wide_t'($signed(PI_Q61));
      q   = num / (wide_t'($signed(PI_Q61)) * 2);
      sgn_dot = n1[0] * l3[0] + n1[1] * l3[1] + n1[2] * l3[2];
      res.angle = (sgn_dot < 0) ? q[TW-1:0] : -q[TW-1:0];
      res.degen = 1'b0;
      return res;
    endfunction

    function void note_quad(quad_t pt);
      pending_q.push_back(torsion_of(pt));
    endfunction

    function void check_torsion(logic signed [TW-1:0] angle, logic degen);
      torsion_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result: torsion_deg %0d degenerate %0b", angle, degen);
        fails++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (angle !== exp_r.angle) begin
        $error("torsion_deg: expected %0d, actual %0d", exp_r.angle, angle);
        fails++;
      end
      if (degen !== exp_r.degen) begin
        $error("degenerate: expected %0b, actual %0b", exp_r.degen, degen);
        fails++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   cycles;

  dad_in_if  #(.CW(CW)) in_if ();
  dad_out_if #(.TW(TW)) out_if ();

  dihedral_angle_four_points #(
    .COORD_WIDTH    (CW),
    .ANGLE_FRAC_BITS(FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  torsion_scoreboard torsion_sb = new();

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("dihedral_angle_four_points test failed");
      $finish;
    end
  end

  // Result side: random stall bursts until the calm tail of the run.
  initial begin
    int burst;
    out_if.ready = 1'b0;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (burst > 0) begin
        burst--;
        out_if.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 7) - 1;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      torsion_sb.check_torsion(out_if.torsion_deg, out_if.degenerate);
    end
  end

  task automatic drive_quad(quad_t pt);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.p1_x = pt[0];  in_if.p1_y = pt[1];  in_if.p1_z = pt[2];
    in_if.p2_x = pt[3];  in_if.p2_y = pt[4];  in_if.p2_z = pt[5];
    in_if.p3_x = pt[6];  in_if.p3_y = pt[7];  in_if.p3_z = pt[8];
    in_if.p4_x = pt[9];  in_if.p4_y = pt[10]; in_if.p4_z = pt[11];
    do @(posedge clk_i); while (!in_if.ready);
    torsion_sb.note_quad(pt);
  endtask

  function automatic quad_t quad_of(int a0, int a1, int a2, int b0, int b1, int b2,
                                    int c0, int c1, int c2, int d0, int d1, int d2);
    quad_t pt;
    pt = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, d0, d1, d2};
    return pt;
  endfunction

  // A chain of bonded points: a random start and short random bond steps.
  function automatic quad_t chain_quad(int step);
    quad_t pt;
    int    base;
    for (int k = 0; k < 3; k++) begin
      base = $signed(24'($urandom));
      pt[k] = base >>> $urandom_range(0, 8);
    end
    for (int k = 3; k < 12; k++) begin
      pt[k] = pt[k - 3] + $signed($urandom_range(0, 2 * step)) - step;
    end
    return pt;
  endfunction

  initial begin
    quad_t pt;
    int    kind;
    int    mx;
    int    mn;
    mx = 8388607;
    mn = -8388608;
    calm = 1'b0;
    in_if.valid = 1'b0;
    in_if.p1_x = '0; in_if.p1_y = '0; in_if.p1_z = '0;
    in_if.p2_x = '0; in_if.p2_y = '0; in_if.p2_z = '0;
    in_if.p3_x = '0; in_if.p3_y = '0; in_if.p3_z = '0;
    in_if.p4_x = '0; in_if.p4_y = '0; in_if.p4_z = '0;
    @(posedge rst_ni);

    // Degenerate: all points equal, and collinear points.
    drive_quad(quad_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_quad(quad_of(0, 0, 0, 1024, 0, 0, 2048, 0, 0, 3072, 1024, 0));
    drive_quad(quad_of(0, 0, 0, 1024, 0, 0, 1024, 1024, 0, 1024, 1024, 0));
    // Trans (coplanar, reads -180), cis (0) and the two right angles.
    drive_quad(quad_of(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, -1024, 0));
    drive_quad(quad_of(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 1024, 0));
    drive_quad(quad_of(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 0, 1024));
    drive_quad(quad_of(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 0, -1024));
    // Coordinate extremes, with the largest differences the fields allow.
    drive_quad(quad_of(mn, mn, mn, mx, mn, mn, mx, mx, mn, mx, mx, mx));
    drive_quad(quad_of(mx, mx, mx, mn, mx, mx, mn, mn, mx, mn, mn, mn));
    drive_quad(quad_of(mn, mx, 0, mx, mn, 0, mn, mn, mx, mx, mx, mn));
    drive_quad(quad_of(mx, 0, mn, 0, mx, mn, mn, 0, mx, 0, mn, mx));
    drive_quad(quad_of(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, 1));
    drive_quad(quad_of(0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 1, -1));
    drive_quad(quad_of(0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1, 1));
    drive_quad(quad_of(mx, mx, mx, mx, mx, mx, 0, 0, 0, 1, 2, 3));
    drive_quad(quad_of(5, 7, 11, mn, 3, 9, mx, -4, 2, 0, 0, mn));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n >= CALM_FROM) calm = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        pt = chain_quad(3000);
      end else if (kind < 14) begin
        pt = chain_quad(4);
      end else if (kind < 16) begin
        // A repeated point or a straight continuation of the chain.
        pt = chain_quad(3000);
        if ($urandom_range(0, 1) == 1) begin
          for (int k = 0; k < 3; k++) pt[6 + k] = pt[3 + k];
        end else begin
          for (int k = 0; k < 3; k++) pt[9 + k] = 2 * pt[6 + k] - pt[3 + k];
        end
      end else begin
        for (int k = 0; k < 12; k++) pt[k] = $signed(24'($urandom));
      end
      drive_quad(pt);
    end

    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (torsion_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (torsion_sb.fails == 0) begin
      $display("dihedral_angle_four_points test passed");
    end else begin
      $display("dihedral_angle_four_points test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
